/* design/pldp_pkg.sv */
// ----------------------------------------------------------------------------
// pldp_pkg
// shared widths and payload types of the page-local direction prefetcher
// ----------------------------------------------------------------------------
package pldp_pkg;

  localparam int ADDR_W     = 64;
  localparam int CORE_IDX_W = 2;

  typedef logic [ADDR_W-1:0]     addr_t;
  typedef logic [CORE_IDX_W-1:0] core_index_t;

endpackage

/* design/pldp_if.sv */
// ----------------------------------------------------------------------------
// pldp_access_if / pldp_prefetch_if
// valid/ready channels for demand accesses and issued prefetches
// ----------------------------------------------------------------------------
interface pldp_access_if;
  import pldp_pkg::*;

  logic        valid;
  logic        ready;
  core_index_t core_index;
  addr_t       access_address;

  modport source (output valid, output core_index, output access_address, input ready);
  modport sink   (input valid, input core_index, input access_address, output ready);
endinterface

interface pldp_prefetch_if;
  import pldp_pkg::*;

  logic  valid;
  logic  ready;
  addr_t prefetch_address;

  modport source (output valid, output prefetch_address, input ready);
  modport sink   (input valid, input prefetch_address, output ready);
endinterface

/* design/pldp_step.sv */
// ----------------------------------------------------------------------------
// pldp_step
// per-core entry update: page check, history push, direction vote, target
// ----------------------------------------------------------------------------
module pldp_step #(
  parameter int HISTORY_LENGTH    = 5,
  parameter int PAGE_OFFSET_BITS  = 12,
  parameter int BLOCK_OFFSET_BITS = 6
) (
  input  logic                                                  page_valid,
  input  logic [pldp_pkg::ADDR_W-PAGE_OFFSET_BITS-1:0]          cur_page,
  input  logic [$clog2(HISTORY_LENGTH+1)-1:0]                   cur_fill,
  input  logic [HISTORY_LENGTH-1:0][PAGE_OFFSET_BITS-BLOCK_OFFSET_BITS-1:0] cur_hist,
  input  logic [pldp_pkg::ADDR_W-PAGE_OFFSET_BITS-1:0]          acc_page,
  input  logic [PAGE_OFFSET_BITS-BLOCK_OFFSET_BITS-1:0]         acc_blk,
  output logic [pldp_pkg::ADDR_W-PAGE_OFFSET_BITS-1:0]          next_page,
  output logic [$clog2(HISTORY_LENGTH+1)-1:0]                   next_fill,
  output logic [HISTORY_LENGTH-1:0][PAGE_OFFSET_BITS-BLOCK_OFFSET_BITS-1:0] next_hist,
  output logic                                                  emit,
  output logic [PAGE_OFFSET_BITS-BLOCK_OFFSET_BITS-1:0]         target_blk
);
  import pldp_pkg::*;

  localparam int BLK_W  = PAGE_OFFSET_BITS - BLOCK_OFFSET_BITS;
  localparam int FILL_W = $clog2(HISTORY_LENGTH + 1);
  localparam int THRESH = (HISTORY_LENGTH - 1) / 2 + 1;

  logic                                hit;
  logic                                full;
  logic                                ascending;
  logic [FILL_W-1:0]                   fill_p;
  logic [FILL_W-1:0]                   ups;
  logic [HISTORY_LENGTH-1:0][BLK_W-1:0] pushed;

  assign hit  = page_valid && (cur_page == acc_page);
  assign full = (cur_fill >= FILL_W'(HISTORY_LENGTH));

  // shift in at the tail once full, else fill the next free slot
  always_comb begin
    pushed = cur_hist;
    if (full) begin
      for (int i = 0; i < HISTORY_LENGTH - 1; i++) begin
        pushed[i] = cur_hist[i+1];
      end
      pushed[HISTORY_LENGTH-1] = acc_blk;
      fill_p = FILL_W'(HISTORY_LENGTH);
    end else begin
      for (int i = 0; i < HISTORY_LENGTH; i++) begin
        if (FILL_W'(i) == cur_fill) begin
          pushed[i] = acc_blk;
        end
      end
      fill_p = cur_fill + FILL_W'(1);
    end
  end

  // count increasing neighbor pairs
  always_comb begin
    ups = '0;
    for (int i = 0; i < HISTORY_LENGTH - 1; i++) begin
      ups = ups + FILL_W'(pushed[i] < pushed[i+1]);
    end
  end

  assign ascending = (fill_p == FILL_W'(HISTORY_LENGTH)) && (ups >= FILL_W'(THRESH));

  always_comb begin
    next_page = acc_page;
    if (hit) begin
      next_fill = fill_p;
      next_hist = pushed;
    end else begin
      next_fill = '0;
      next_hist = cur_hist;
    end
  end

  // a full, mostly ascending history steps back one block, otherwise forward
  always_comb begin
    if (ascending) begin
      emit       = hit && (acc_blk != '0);
      target_blk = acc_blk - BLK_W'(1);
    end else begin
      emit       = hit && (acc_blk != '1);
      target_blk = acc_blk + BLK_W'(1);
    end
  end

endmodule

/* design/page_local_direction_prefetcher.sv */
// ----------------------------------------------------------------------------
// page_local_direction_prefetcher
// per-core page tracker that issues at most one in-page prefetch per demand access
// ----------------------------------------------------------------------------
//
//   channel    dir  handshake     payload
//   access     in   valid/ready   core_index, access_address
//   prefetch   out  valid/ready   prefetch_address (zero or one per access)
//
// one access per cycle while the update stage is not held by a stalled prefetch;
// a prefetch passes the state memory read register and then the output register
// state memory is read at accept and written back as the update stage advances; a
// back-to-back access to the same core takes the written-back entry by bypass
// rst (synchronous) clears the per-core page valid bits and the pipeline;
// memory contents are left as they are, an invalid core is a page change
// a stalled prefetch word holds the update stage, which then holds access
// ready low until the output register drains
//
module page_local_direction_prefetcher #(
  parameter int CORE_COUNT        = 4,
  parameter int HISTORY_LENGTH    = 5,
  parameter int PAGE_OFFSET_BITS  = 12,
  parameter int BLOCK_OFFSET_BITS = 6
) (
  input logic             clk,
  input logic             rst,
  pldp_access_if.sink     access,
  pldp_prefetch_if.source prefetch
);
  import pldp_pkg::*;

  localparam int PAGE_W  = ADDR_W - PAGE_OFFSET_BITS;
  localparam int BLK_W   = PAGE_OFFSET_BITS - BLOCK_OFFSET_BITS;
  localparam int FILL_W  = $clog2(HISTORY_LENGTH + 1);
  localparam int HIST_W  = HISTORY_LENGTH * BLK_W;
  localparam int ENTRY_W = PAGE_W + FILL_W + HIST_W;
  localparam int CIW     = (CORE_COUNT > 1) ? $clog2(CORE_COUNT) : 1;

  // per-core entry: {page, fill count, history oldest-first}
  logic [ENTRY_W-1:0]    state_mem [CORE_COUNT];
  logic [ENTRY_W-1:0]    rd_entry;
  logic [ENTRY_W-1:0]    fwd_entry;
  logic                  fwd;
  logic [CORE_COUNT-1:0] page_valid;

  // access side
  logic           accept;
  logic [CIW-1:0] in_idx;
  logic           in_range;

  // update stage
  logic             s1_valid;
  logic [CIW-1:0]   s1_idx;
  logic             s1_in_range;
  logic [PAGE_W-1:0] s1_page;
  logic [BLK_W-1:0] s1_blk;
  logic             advance;

  // current entry after bypass
  logic [ENTRY_W-1:0]                   cur_entry;
  logic [PAGE_W-1:0]                    cur_page;
  logic [FILL_W-1:0]                    cur_fill;
  logic [HISTORY_LENGTH-1:0][BLK_W-1:0] cur_hist;

  // updated entry
  logic [PAGE_W-1:0]                    next_page;
  logic [FILL_W-1:0]                    next_fill;
  logic [HISTORY_LENGTH-1:0][BLK_W-1:0] next_hist;
  logic [ENTRY_W-1:0]                   new_entry;
  logic                                 step_emit;
  logic [BLK_W-1:0]                     target_blk;

  // output register
  logic  out_valid;
  addr_t out_addr;

  assign in_idx   = CIW'(access.core_index);
  assign in_range = (32'(access.core_index) < CORE_COUNT);

  assign advance      = s1_valid && (!out_valid || prefetch.ready);
  assign access.ready = !s1_valid || advance;
  assign accept       = access.valid && access.ready;

  // state memory: one read at accept, one write-back as the update stage leaves
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_entry <= state_mem[in_idx];
    end
    if (advance && s1_in_range) begin
      state_mem[s1_idx] <= new_entry;
    end
  end

  // bypass for a same-core access that reads while the previous one writes
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd <= 1'b0;
    end else if (accept) begin
      fwd <= advance && s1_in_range && (s1_idx == in_idx);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      fwd_entry <= new_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      page_valid <= '0;
    end else if (advance && s1_in_range) begin
      page_valid[s1_idx] <= 1'b1;
    end
  end

  // update stage registers
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_idx      <= in_idx;
      s1_in_range <= in_range;
      s1_page     <= access.access_address[ADDR_W-1:PAGE_OFFSET_BITS];
      s1_blk      <= access.access_address[PAGE_OFFSET_BITS-1:BLOCK_OFFSET_BITS];
    end
  end

  assign cur_entry = fwd ? fwd_entry : rd_entry;
  assign cur_page  = cur_entry[ENTRY_W-1 -: PAGE_W];
  assign cur_fill  = cur_entry[HIST_W +: FILL_W];
  assign cur_hist  = cur_entry[HIST_W-1:0];

  pldp_step #(
    .HISTORY_LENGTH   (HISTORY_LENGTH),
    .PAGE_OFFSET_BITS (PAGE_OFFSET_BITS),
    .BLOCK_OFFSET_BITS(BLOCK_OFFSET_BITS)
  ) u_step (
    .page_valid (page_valid[s1_idx]),
    .cur_page   (cur_page),
    .cur_fill   (cur_fill),
    .cur_hist   (cur_hist),
    .acc_page   (s1_page),
    .acc_blk    (s1_blk),
    .next_page  (next_page),
    .next_fill  (next_fill),
    .next_hist  (next_hist),
    .emit       (step_emit),
    .target_blk (target_blk)
  );

  assign new_entry = {next_page, next_fill, next_hist};

  // prefetch word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && s1_in_range && step_emit) begin
      out_valid <= 1'b1;
    end else if (prefetch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_in_range && step_emit) begin
      out_addr <= {s1_page, target_blk, {BLOCK_OFFSET_BITS{1'b0}}};
    end
  end

  assign prefetch.valid            = out_valid;
  assign prefetch.prefetch_address = out_addr;

endmodule
